@@ src/differential_evolution_step_top_defines.svh @@
// assertion macros shared by the differential evolution checker
`ifndef DIFFERENTIAL_EVOLUTION_STEP_TOP_DEFINES_SVH
`define DIFFERENTIAL_EVOLUTION_STEP_TOP_DEFINES_SVH

// same-cycle implication, gated by reset
`define DES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, gated by reset
`define DES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/des_pkg.sv @@
// shared types, constants and codes of the differential evolution step engine
`timescale 1ns / 1ps
package des_pkg;

    localparam int POP_SIZE  = 16;
    localparam int IDX_W     = $clog2(POP_SIZE);
    localparam int VEC_LEN   = 3;
    localparam int ELEM_BITS = 24;
    localparam int FRAC      = 20;
    localparam int FIT_W     = 44;
    localparam int CNT_W     = $clog2(POP_SIZE + 1);
    localparam int FIT_LAT   = 5;

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef elem_t [VEC_LEN-1:0] vec_t;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_EVOLVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_COMMIT = 2'd3
    } des_cmd_t;

    typedef enum logic [1:0] {
        REG_F_SCALE    = 2'd0,
        REG_CROSS_THR  = 2'd1,
        REG_LOW_BOUND  = 2'd2,
        REG_HIGH_BOUND = 2'd3
    } des_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_DIFF,
        ST_TRIAL,
        ST_EVAL,
        ST_DECIDE,
        ST_COMMIT,
        ST_FINISH
    } des_state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_PLAIN,
        RES_VEC
    } des_res_t;

    typedef struct packed {
        logic             cap;
        logic             rd_en;
        logic             rd_sel;
        logic             lat_a;
        logic             prod_en;
        logic             trial_en;
        logic             fit_sel_cur;
        logic             ft_cap;
        logic             fc_cap;
        logic             commit_rd;
        logic             commit_wr;
        logic [IDX_W-1:0] commit_idx_rd;
        logic [IDX_W-1:0] commit_idx_wr;
        logic             clear_marks;
        logic             load_wr;
        des_res_t         res;
    } des_ctrl_t;

    typedef struct packed {
        des_cmd_t cmd;
        logic     bad;
        logic     out_free;
    } des_stat_t;

endpackage

@@ src/des_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
interface des_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  target;
    logic [1:0]  elem_index;
    logic signed [23:0] value;
    logic [3:0]  pick_a;
    logic [3:0]  pick_b;
    logic [3:0]  pick_c;
    logic [1:0]  keep_index;
    logic [15:0] draw_0;
    logic [15:0] draw_1;
    logic [15:0] draw_2;

    modport source (output valid, cmd, target, elem_index, value, pick_a, pick_b, pick_c,
                    keep_index, draw_0, draw_1, draw_2, input ready);
    modport sink (input valid, cmd, target, elem_index, value, pick_a, pick_b, pick_c,
                  keep_index, draw_0, draw_1, draw_2, output ready);
endinterface

interface des_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic signed [23:0] out_elem_0;
    logic signed [23:0] out_elem_1;
    logic signed [23:0] out_elem_2;
    logic [43:0] fitness;
    logic        replaced;

    modport source (output valid, status, out_elem_0, out_elem_1, out_elem_2, fitness,
                    replaced, input ready);
    modport sink (input valid, status, out_elem_0, out_elem_1, out_elem_2, fitness,
                  replaced, output ready);
endinterface

@@ src/differential_evolution_step_top.sv @@
// states: load and rejected evolve pass RD0, FINISH; commit RD0, COMMIT, FINISH; read and
// evolve RD0, RD1, DIFF, TRIAL, EVAL (fitness pipeline of five stages run twice), DECIDE
// throughput: one request at a time, the next taken the cycle after the result is
// registered; a result waits in DECIDE or FINISH while the output is stalled
// reset: config registers return to their defaults and shadow marks clear;
// live and shadow store contents are undefined until written
`timescale 1ns / 1ps
module differential_evolution_step_top
    import des_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    des_in_if.sink      in_chan,
    des_out_if.source   out_chan
);

    // command and status bundles between sequencer and datapath
    des_ctrl_t ctrl;
    des_stat_t stat;

    // sequencer: walks the read, mutate, evaluate, decide and commit steps of each request
    des_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // datapath: stores, trial lanes, fitness pipeline, result register
    des_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

endmodule

@@ src/des_fitness.sv @@
// five-stage fitness pipeline for one vector
`timescale 1ns / 1ps
module des_fitness
    import des_pkg::*;
(
    input  logic             clk,
    input  vec_t             vec_in,
    output logic [FIT_W-1:0] fit_out
);

    localparam int SQ_W  = 2 * ELEM_BITS;
    localparam int Q_W   = SQ_W + 2;
    localparam int M_W   = Q_W - FRAC;
    localparam int D_W   = ELEM_BITS + 1;
    localparam int SUM_W = 64;
    localparam logic signed [D_W-1:0] ONE = D_W'(1 << FRAC);

    logic signed [SQ_W-1:0]  sq0_reg, pr_reg;
    logic signed [ELEM_BITS-1:0] x1_reg, x2_reg;
    logic signed [D_W-1:0]   d0_reg, d1_reg;
    logic [M_W-1:0]          ma_reg, mb_reg;
    logic [D_W-1:0]          a0_reg, a1_reg;
    logic [2*M_W-1:0]        sa_reg, sb_reg;
    logic [2*D_W-1:0]        s0_reg, s1_reg;
    logic [SUM_W-1:0]        ta_reg, tb_reg, u0_reg, u1_reg;
    logic [FIT_W-1:0]        fit_reg;

    logic signed [Q_W-1:0]   qa, qb;
    logic [Q_W-1:0]          qa_mag, qb_mag;
    logic [SUM_W-1:0]        sum;

    always_comb
    begin
        qa = (Q_W'(x1_reg) <<< FRAC) - Q_W'(sq0_reg);
        qb = (Q_W'(x2_reg) <<< FRAC) - Q_W'(pr_reg);
        qa_mag = qa[Q_W-1] ? Q_W'(-qa) : Q_W'(qa);
        qb_mag = qb[Q_W-1] ? Q_W'(-qb) : Q_W'(qb);
        sum = ta_reg + tb_reg + u0_reg + u1_reg;
    end

    always_ff @(posedge clk)
    begin
        // products and plain brackets
        sq0_reg <= vec_in[0] * vec_in[0];
        pr_reg  <= vec_in[2] * vec_in[1];
        x1_reg  <= vec_in[1];
        x2_reg  <= vec_in[2];
        d0_reg  <= ONE - D_W'(vec_in[0]);
        d1_reg  <= ONE - D_W'(vec_in[1]);
        // round scaled brackets to Q.20 magnitude
        ma_reg  <= M_W'(qa_mag >> FRAC) + M_W'(qa_mag[FRAC-1]);
        mb_reg  <= M_W'(qb_mag >> FRAC) + M_W'(qb_mag[FRAC-1]);
        a0_reg  <= d0_reg[D_W-1] ? D_W'(-d0_reg) : D_W'(d0_reg);
        a1_reg  <= d1_reg[D_W-1] ? D_W'(-d1_reg) : D_W'(d1_reg);
        // squares
        sa_reg  <= ma_reg * ma_reg;
        sb_reg  <= mb_reg * mb_reg;
        s0_reg  <= a0_reg * a0_reg;
        s1_reg  <= a1_reg * a1_reg;
        // weight the scaled brackets
        ta_reg  <= SUM_W'(sa_reg) * SUM_W'(100);
        tb_reg  <= SUM_W'(sb_reg) * SUM_W'(100);
        u0_reg  <= SUM_W'(s0_reg);
        u1_reg  <= SUM_W'(s1_reg);
        // sum and round to Q.20, never exceeds the field range
        fit_reg <= FIT_W'(sum >> FRAC) + FIT_W'(sum[FRAC-1]);
    end

    assign fit_out = fit_reg;

endmodule

@@ src/des_datapath.sv @@
// stores, config registers, trial lanes and result register
`timescale 1ns / 1ps
module des_datapath
    import des_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  des_ctrl_t       ctrl,
    output des_stat_t       stat,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [23:0]     cfg_data,
    des_in_if.sink          in_chan,
    des_out_if.source       out_chan
);

    localparam int P_W = ELEM_BITS + 18;
    localparam int R_W = P_W - 16 + 1;
    localparam int E_W = R_W + 1;

    logic [15:0]            f_scale_reg;
    logic [16:0]            thr_reg;
    elem_t                  low_reg, high_reg;

    des_cmd_t               cmd_reg;
    logic [IDX_W-1:0]       tgt_reg, sa_reg, sb_reg, sc_reg;
    logic [1:0]             ei_reg, keep_reg;
    elem_t                  val_reg;
    logic [15:0]            draw_reg [VEC_LEN];
    logic                   bad_reg;

    elem_t                  live_mem [VEC_LEN][POP_SIZE];
    vec_t                   shadow_mem [POP_SIZE];
    logic [POP_SIZE-1:0]    marks_reg;
    vec_t                   rd0_reg, rd1_reg, sh_rd_reg;
    vec_t                   cur_reg, base_reg, trial_reg;
    logic signed [P_W-1:0]  prod_reg [VEC_LEN];
    logic [FIT_W-1:0]       ft_reg, fc_reg, fit_out;

    logic                   out_valid_reg;
    logic                   status_reg, replaced_reg;
    vec_t                   out_vec_reg;
    logic [FIT_W-1:0]       fitness_reg;

    logic [IDX_W-1:0]       pa, pb, pc, sw, ra0, ra1, wr_addr;
    logic                   bad_now, win, sh_we;
    logic [VEC_LEN-1:0]     wr_en;
    vec_t                   wr_vec, trial_next, fit_in;

    // sort the picks and check them
    always_comb
    begin
        pa = in_chan.pick_a;
        pb = in_chan.pick_b;
        pc = in_chan.pick_c;
        sw = '0;
        if (pa > pb) begin sw = pa; pa = pb; pb = sw; end
        if (pb > pc) begin sw = pb; pb = pc; pc = sw; end
        if (pa > pb) begin sw = pa; pa = pb; pb = sw; end
        bad_now = (pa == pb) || (pb == pc) || (pa == in_chan.target)
               || (pb == in_chan.target) || (pc == in_chan.target);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_scale_reg <= 16'd64225;
            thr_reg     <= 17'd52429;
            low_reg     <= -24'sd2097152;
            high_reg    <= 24'sd2097152;
        end
        else if (cfg_we)
        begin
            case (des_reg_t'(cfg_index))
                REG_F_SCALE:    f_scale_reg <= cfg_data[15:0];
                REG_CROSS_THR:  thr_reg <= cfg_data[16:0];
                REG_LOW_BOUND:  low_reg <= cfg_data;
                REG_HIGH_BOUND: high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap && in_chan.valid)
        begin
            cmd_reg     <= des_cmd_t'(in_chan.cmd);
            tgt_reg     <= in_chan.target;
            ei_reg      <= in_chan.elem_index;
            val_reg     <= in_chan.value;
            keep_reg    <= in_chan.keep_index;
            sa_reg      <= pa;
            sb_reg      <= pb;
            sc_reg      <= pc;
            draw_reg[0] <= in_chan.draw_0;
            draw_reg[1] <= in_chan.draw_1;
            draw_reg[2] <= in_chan.draw_2;
            bad_reg     <= bad_now;
        end
    end

    assign in_chan.ready = ctrl.cap;

    // live store write and read ports
    always_comb
    begin
        ra0 = ctrl.rd_sel ? sb_reg : tgt_reg;
        ra1 = ctrl.rd_sel ? sc_reg : sa_reg;
        wr_en = '0;
        if (ctrl.commit_wr)
        begin
            wr_addr = ctrl.commit_idx_wr;
            wr_vec  = sh_rd_reg;
            wr_en   = {VEC_LEN{marks_reg[ctrl.commit_idx_wr]}};
        end
        else
        begin
            wr_addr = tgt_reg;
            wr_vec  = {VEC_LEN{val_reg}};
            if (ctrl.load_wr && (ei_reg < 2'(VEC_LEN)))
                wr_en[ei_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < VEC_LEN; k++)
        begin
            if (wr_en[k])
                live_mem[k][wr_addr] <= wr_vec[k];
            if (ctrl.rd_en)
            begin
                rd0_reg[k] <= live_mem[k][ra0];
                rd1_reg[k] <= live_mem[k][ra1];
            end
        end
        if (sh_we)
            shadow_mem[tgt_reg] <= trial_reg;
        if (ctrl.commit_rd)
            sh_rd_reg <= shadow_mem[ctrl.commit_idx_rd];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marks_reg <= '0;
        else if (ctrl.clear_marks)
            marks_reg <= '0;
        else if (sh_we)
            marks_reg[tgt_reg] <= 1'b1;
    end

    // mutation, crossover and clamp per lane
    always_comb
    begin
        for (int k = 0; k < VEC_LEN; k++)
        begin
            logic [P_W-1:0]        mag;
            logic [R_W-1:0]        r;
            logic signed [E_W-1:0] e;
            logic                  take;
            mag  = prod_reg[k][P_W-1] ? P_W'(-prod_reg[k]) : P_W'(prod_reg[k]);
            r    = R_W'(mag >> 16) + R_W'(mag[15]);
            e    = prod_reg[k][P_W-1] ? E_W'(base_reg[k]) - E_W'(r)
                                      : E_W'(base_reg[k]) + E_W'(r);
            take = (keep_reg == 2'(k)) || ({1'b0, draw_reg[k]} < thr_reg);
            if (!take)
                e = E_W'(cur_reg[k]);
            if (e < E_W'(low_reg))
                e = E_W'(low_reg);
            if (e > E_W'(high_reg))
                e = E_W'(high_reg);
            trial_next[k] = ELEM_BITS'(e);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.lat_a)
        begin
            cur_reg  <= rd0_reg;
            base_reg <= rd1_reg;
        end
        for (int k = 0; k < VEC_LEN; k++)
        begin
            if (ctrl.prod_en)
                prod_reg[k] <= (P_W'(rd0_reg[k]) - P_W'(rd1_reg[k]))
                             * $signed(P_W'({1'b0, f_scale_reg}));
        end
        if (ctrl.trial_en)
            trial_reg <= trial_next;
        if (ctrl.ft_cap)
            ft_reg <= fit_out;
        if (ctrl.fc_cap)
            fc_reg <= fit_out;
    end

    assign fit_in = ctrl.fit_sel_cur ? cur_reg : trial_reg;

    des_fitness u_fitness
    (
        .clk     (clk),
        .vec_in  (fit_in),
        .fit_out (fit_out)
    );

    // result register
    assign win   = (cmd_reg == CMD_EVOLVE) && (ft_reg < fc_reg);
    assign sh_we = (ctrl.res == RES_VEC) && win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.res != RES_NONE)
            out_valid_reg <= 1'b1;
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.res)
            RES_PLAIN:
            begin
                status_reg   <= (cmd_reg == CMD_EVOLVE) && bad_reg;
                out_vec_reg  <= '0;
                fitness_reg  <= '0;
                replaced_reg <= 1'b0;
            end
            RES_VEC:
            begin
                status_reg   <= 1'b0;
                out_vec_reg  <= win ? trial_reg : cur_reg;
                fitness_reg  <= win ? ft_reg : fc_reg;
                replaced_reg <= win;
            end
            default: ;
        endcase
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.status     = status_reg;
    assign out_chan.out_elem_0 = out_vec_reg[0];
    assign out_chan.out_elem_1 = out_vec_reg[1];
    assign out_chan.out_elem_2 = out_vec_reg[2];
    assign out_chan.fitness    = fitness_reg;
    assign out_chan.replaced   = replaced_reg;

    assign stat.cmd      = cmd_reg;
    assign stat.bad      = bad_reg;
    assign stat.out_free = !out_valid_reg || out_chan.ready;

endmodule

@@ src/des_controller.sv @@
// command sequencer of the differential evolution step engine
`timescale 1ns / 1ps
module des_controller
    import des_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  des_stat_t  stat,
    output des_ctrl_t  ctrl
);

    des_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_RD0;
            end
            ST_RD0:
            begin
                case (stat.cmd)
                    CMD_LOAD:   state_next = ST_FINISH;
                    CMD_COMMIT: state_next = ST_COMMIT;
                    CMD_EVOLVE: state_next = stat.bad ? ST_FINISH : ST_RD1;
                    default:    state_next = ST_RD1;
                endcase
            end
            ST_RD1:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_TRIAL;
            ST_TRIAL: state_next = ST_EVAL;
            ST_EVAL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FIT_LAT + 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
                if (stat.out_free)
                    state_next = ST_IDLE;
            ST_COMMIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(POP_SIZE))
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl               = '0;
        ctrl.res           = RES_NONE;
        ctrl.commit_idx_rd = cnt_reg[IDX_W-1:0];
        ctrl.commit_idx_wr = IDX_W'(cnt_reg - 1'b1);
        case (state_reg)
            ST_IDLE:  ctrl.cap = 1'b1;
            ST_RD0:   ctrl.rd_en = 1'b1;
            ST_RD1:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = 1'b1;
                ctrl.lat_a  = 1'b1;
            end
            ST_DIFF:  ctrl.prod_en = 1'b1;
            ST_TRIAL: ctrl.trial_en = 1'b1;
            ST_EVAL:
            begin
                ctrl.fit_sel_cur = (cnt_reg == CNT_W'(1));
                ctrl.ft_cap      = (cnt_reg == CNT_W'(FIT_LAT));
                ctrl.fc_cap      = (cnt_reg == CNT_W'(FIT_LAT + 1));
            end
            ST_DECIDE:
                if (stat.out_free)
                    ctrl.res = RES_VEC;
            ST_COMMIT:
            begin
                ctrl.commit_rd   = (cnt_reg < CNT_W'(POP_SIZE));
                ctrl.commit_wr   = (cnt_reg != '0);
                ctrl.clear_marks = (cnt_reg == CNT_W'(POP_SIZE));
            end
            ST_FINISH:
                if (stat.out_free)
                begin
                    ctrl.res     = RES_PLAIN;
                    ctrl.load_wr = (stat.cmd == CMD_LOAD);
                end
            default: ;
        endcase
    end

endmodule

@@ src/des_checker.sv @@
// port-level checks of the differential evolution step engine and their binding
`timescale 1ns / 1ps
`include "differential_evolution_step_top_defines.svh"
module des_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_status,
    input logic [23:0] out_elem_0,
    input logic [43:0] out_fitness,
    input logic        out_replaced
);

    `DES_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `DES_ASSERT_NXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken while busy")
    `DES_ASSERT_IMP(a_reject_zero, out_valid && out_status, (out_fitness == '0) && !out_replaced && (out_elem_0 == '0), "rejected result not cleared")

endmodule

bind differential_evolution_step_top des_checker u_des_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_status   (out_chan.status),
    .out_elem_0   (out_chan.out_elem_0),
    .out_fitness  (out_chan.fitness),
    .out_replaced (out_chan.replaced)
);

@@ tb/tb.sv @@
// self-checking testbench for the differential evolution step engine
`timescale 1ns / 1ps
module tb;
    import des_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_SETTLE = 25;      // longer than the slowest request (commit sweep)
    localparam int STALL_LIMIT = 4000;    // cycles with no handshake on either channel
    localparam int ITEMS_PER_PHASE = 65;
    localparam logic [63:0] FIT_CEIL = 64'h0000_0FFF_FFFF_FFFF;
    localparam longint ONE_Q20 = 64'sd1 << FRAC;

    // one request of the input channel
    typedef struct {
        des_cmd_t           cmd;
        logic [3:0]         target;
        logic [1:0]         elem_index;
        logic signed [23:0] value;
        logic [3:0]         pick_a;
        logic [3:0]         pick_b;
        logic [3:0]         pick_c;
        logic [1:0]         keep_index;
        logic [15:0]        draw [VEC_LEN];
    } de_request_t;

    // one result of the output channel
    typedef struct {
        logic               status;
        logic signed [23:0] elem [VEC_LEN];
        logic [43:0]        fitness;
        logic               replaced;
    } de_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [23:0] cfg_data;

    des_in_if  req_if ();
    des_out_if res_if ();

    differential_evolution_step_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (req_if),
        .out_chan  (res_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: population copies, marks and register values
    // ------------------------------------------------------------------
    longint      live_vec [POP_SIZE][VEC_LEN];
    longint      shadow_vec [POP_SIZE][VEC_LEN];
    bit          shadow_mark [POP_SIZE];
    int unsigned mut_factor;
    int unsigned cross_level;
    longint      clamp_lo;
    longint      clamp_hi;

    de_request_t pending_requests [$];
    de_result_t  expected_results [$];
    bit          failed = 1'b0;
    bit          burst_mode = 1'b0;   // no idling on either side while set

    // which elements of each entry the stimulus has loaded so far
    logic [2:0] loaded_elems [POP_SIZE];

    // ------------------------------------------------------------------
    // fixed point helpers, all on 64-bit unsigned magnitudes
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag_of(input longint t);
        return (t < 0) ? 64'(-t) : 64'(t);
    endfunction

    // round to nearest, halves away from zero, on a magnitude
    function automatic logic [63:0] round_shift(input logic [63:0] u, input int s);
        return (u >> s) + ((u >> (s - 1)) & 64'd1);
    endfunction

    function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // 100 * (bracket rounded to q20)^2
    function automatic logic [63:0] weighted_square(input longint q40);
        logic [63:0] m;
        m = round_shift(mag_of(q40), FRAC);
        return mul_sat(64'd100, mul_sat(m, m));
    endfunction

    function automatic logic [63:0] plain_square(input longint q20);
        logic [63:0] m;
        m = mag_of(q20);
        return mul_sat(m, m);
    endfunction

    // objective of one vector, q24.20 saturating
    function automatic logic [43:0] objective(input longint x0, input longint x1,
                                              input longint x2);
        logic [63:0] sum;
        logic [63:0] r;
        sum = weighted_square(x1 * ONE_Q20 - x0 * x0);
        sum = add_sat(sum, plain_square(ONE_Q20 - x0));
        sum = add_sat(sum, weighted_square(x2 * ONE_Q20 - x2 * x1));
        sum = add_sat(sum, plain_square(ONE_Q20 - x1));
        r = round_shift(sum, FRAC);
        if (r > FIT_CEIL)
            r = FIT_CEIL;
        return r[43:0];
    endfunction

    // ------------------------------------------------------------------
    // predictor: applies one request to the state, returns its result
    // ------------------------------------------------------------------
    function automatic de_result_t predict_de_result(input de_request_t r);
        de_result_t res;
        int         tgt;
        int         pa;
        int         pb;
        int         pc;
        int         t;
        longint     trial [VEC_LEN];
        longint     prod;
        longint     e;
        logic [63:0] rmag;
        logic [43:0] fit_trial;
        logic [43:0] fit_live;
        res.status = 1'b0;
        res.fitness = '0;
        res.replaced = 1'b0;
        foreach (res.elem[i])
            res.elem[i] = '0;
        tgt = int'(r.target);
        pa = int'(r.pick_a);
        pb = int'(r.pick_b);
        pc = int'(r.pick_c);
        case (r.cmd)
            CMD_COMMIT:
            begin
                for (int i = 0; i < POP_SIZE; i++)
                begin
                    if (shadow_mark[i])
                        live_vec[i] = shadow_vec[i];
                    shadow_mark[i] = 1'b0;
                end
            end
            CMD_LOAD:
            begin
                if (r.elem_index < VEC_LEN)
                    live_vec[tgt][r.elem_index] = longint'(r.value);
            end
            CMD_READ:
            begin
                foreach (res.elem[i])
                    res.elem[i] = live_vec[tgt][i][23:0];
                res.fitness = objective(live_vec[tgt][0], live_vec[tgt][1], live_vec[tgt][2]);
            end
            default:
            begin
                if (pa == pb || pa == pc || pb == pc || pa == tgt || pb == tgt || pc == tgt)
                begin
                    res.status = 1'b1;
                    return res;
                end
                // ascending order: base, plus, minus
                if (pa > pb) begin t = pa; pa = pb; pb = t; end
                if (pb > pc) begin t = pb; pb = pc; pc = t; end
                if (pa > pb) begin t = pa; pa = pb; pb = t; end
                for (int i = 0; i < VEC_LEN; i++)
                begin
                    if (i == int'(r.keep_index) || r.draw[i] < cross_level)
                    begin
                        prod = (live_vec[pb][i] - live_vec[pc][i]) * longint'(mut_factor);
                        rmag = round_shift(mag_of(prod), 16);
                        e = live_vec[pa][i] + ((prod < 0) ? -longint'(rmag) : longint'(rmag));
                    end
                    else
                        e = live_vec[tgt][i];
                    if (e < clamp_lo)
                        e = clamp_lo;
                    if (e > clamp_hi)
                        e = clamp_hi;
                    trial[i] = e;
                end
                fit_trial = objective(trial[0], trial[1], trial[2]);
                fit_live = objective(live_vec[tgt][0], live_vec[tgt][1], live_vec[tgt][2]);
                if (fit_trial < fit_live)
                begin
                    shadow_vec[tgt] = trial;
                    shadow_mark[tgt] = 1'b1;
                    foreach (res.elem[i])
                        res.elem[i] = trial[i][23:0];
                    res.fitness = fit_trial;
                    res.replaced = 1'b1;
                end
                else
                begin
                    foreach (res.elem[i])
                        res.elem[i] = live_vec[tgt][i][23:0];
                    res.fitness = fit_live;
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random gap lengths: mostly none or short, a few long
    // ------------------------------------------------------------------
    function automatic int unsigned gap_length();
        int unsigned r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // request driver: one request in flight on the channel at a time
    // ------------------------------------------------------------------
    de_request_t driven_req;
    int unsigned send_gap;
    bit          req_fire;
    bit          res_fire;

    assign req_fire = req_if.valid && req_if.ready;
    assign res_fire = res_if.valid && res_if.ready;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end
        else if (!req_if.valid || req_fire)
        begin
            // prediction happens on acceptance, in request order
            if (req_fire)
                expected_results.insert(expected_results.size(),
                                        predict_de_result(driven_req));
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                req_if.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                driven_req = pending_requests.pop_front();
                req_if.cmd        <= driven_req.cmd;
                req_if.target     <= driven_req.target;
                req_if.elem_index <= driven_req.elem_index;
                req_if.value      <= driven_req.value;
                req_if.pick_a     <= driven_req.pick_a;
                req_if.pick_b     <= driven_req.pick_b;
                req_if.pick_c     <= driven_req.pick_c;
                req_if.keep_index <= driven_req.keep_index;
                req_if.draw_0     <= driven_req.draw[0];
                req_if.draw_1     <= driven_req.draw[1];
                req_if.draw_2     <= driven_req.draw[2];
                req_if.valid      <= 1'b1;
                send_gap = gap_length();
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result monitor with random back-pressure
    // ------------------------------------------------------------------
    int unsigned recv_stall;

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        de_result_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (res_fire)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(res_if.status));
                    check_field("out_elem_0", 64'(want.elem[0]), 64'(res_if.out_elem_0));
                    check_field("out_elem_1", 64'(want.elem[1]), 64'(res_if.out_elem_1));
                    check_field("out_elem_2", 64'(want.elem[2]), 64'(res_if.out_elem_2));
                    check_field("fitness", 64'(want.fitness), 64'(res_if.fitness));
                    check_field("replaced", 64'(want.replaced), 64'(res_if.replaced));
                end
            end
            // ready changes once per cycle, independent of valid
            if (recv_stall != 0)
            begin
                recv_stall = recv_stall - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall = gap_length();
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog on handshake activity
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (req_fire || res_fire || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input des_cmd_t cmd, input int tgt, input int ei,
                                 input logic signed [23:0] val, input int pa, input int pb,
                                 input int pc, input int keep, input int d0, input int d1,
                                 input int d2);
        de_request_t r;
        r.cmd = cmd;
        r.target = 4'(tgt);
        r.elem_index = 2'(ei);
        r.value = val;
        r.pick_a = 4'(pa);
        r.pick_b = 4'(pb);
        r.pick_c = 4'(pc);
        r.keep_index = 2'(keep);
        r.draw[0] = 16'(d0);
        r.draw[1] = 16'(d1);
        r.draw[2] = 16'(d2);
        if (cmd == CMD_LOAD && ei < VEC_LEN)
            loaded_elems[tgt][ei] = 1'b1;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // register write, only called while the engine is idle
    task automatic write_reg(input des_reg_t idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_F_SCALE:   mut_factor = 32'(data[15:0]);
            REG_CROSS_THR: cross_level = 32'(data[16:0]);
            REG_LOW_BOUND: clamp_lo = longint'(signed'(data));
            default:       clamp_hi = longint'(signed'(data));
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // element values: mostly near the bounds region, some full range and corners
    function automatic logic signed [23:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 24'($signed($urandom_range(0, 5242880)) - 2621440);
        if (r < 85)
            return 24'($urandom);
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'h100000;
            default: return 24'hF00000;
        endcase
    endfunction

    function automatic int pick_draw();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic bit entry_full(input int idx);
        return &loaded_elems[idx];
    endfunction

    // one random request, never touching an entry before it is loaded
    task automatic queue_random_request();
        int unsigned sel;
        int tgt;
        int pa;
        int pb;
        int pc;
        bit found;
        sel = $urandom_range(0, 99);
        tgt = $urandom_range(0, POP_SIZE - 1);
        if (sel < 30 || !entry_full(tgt))
        begin
            // a few loads to the unused element slot, which the engine ignores
            queue_request(CMD_LOAD, tgt, ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                          pick_value(), $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 3), pick_draw(), pick_draw(),
                          pick_draw());
        end
        else if (sel < 50)
            queue_request(CMD_READ, tgt, $urandom_range(0, 3), 24'($urandom),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 3), pick_draw(), pick_draw(), pick_draw());
        else if (sel < 58)
            queue_request(CMD_COMMIT, tgt, $urandom_range(0, 3), 24'($urandom),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 3), pick_draw(), pick_draw(), pick_draw());
        else
        begin
            found = 1'b0;
            if (sel < 92)
            begin
                for (int k = 0; k < 40 && !found; k++)
                begin
                    pa = $urandom_range(0, 15);
                    pb = $urandom_range(0, 15);
                    pc = $urandom_range(0, 15);
                    found = pa != pb && pa != pc && pb != pc && pa != tgt && pb != tgt &&
                            pc != tgt && entry_full(pa) && entry_full(pb) && entry_full(pc);
                end
            end
            if (!found)
            begin
                // broken picks: a repeated pick or one equal to the target
                pa = $urandom_range(0, 15);
                pc = $urandom_range(0, 15);
                pb = $urandom_range(0, 1) ? pa : tgt;
            end
            queue_request(CMD_EVOLVE, tgt, $urandom_range(0, 3), 24'($urandom), pa, pb, pc,
                          $urandom_range(0, 3), pick_draw(), pick_draw(), pick_draw());
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_we = 1'b0;
        cfg_index = REG_F_SCALE;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_LOAD;
        req_if.target = '0;
        req_if.elem_index = '0;
        req_if.value = '0;
        req_if.pick_a = '0;
        req_if.pick_b = '0;
        req_if.pick_c = '0;
        req_if.keep_index = '0;
        req_if.draw_0 = '0;
        req_if.draw_1 = '0;
        req_if.draw_2 = '0;
        res_if.ready = 1'b0;
        // reset defaults of the registers, and a clean model
        mut_factor = 64225;
        cross_level = 52429;
        clamp_lo = -2097152;
        clamp_hi = 2097152;
        foreach (live_vec[i, j])
        begin
            live_vec[i][j] = 0;
            shadow_vec[i][j] = 0;
        end
        foreach (shadow_mark[i])
        begin
            shadow_mark[i] = 1'b0;
            loaded_elems[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme elements, the optimum, and a few ordinary vectors
        queue_request(CMD_LOAD, 0, 0, 24'h800000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 0, 1, 24'h7FFFFF, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 0, 2, 24'h000000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 1, 0, 24'h100000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 1, 1, 24'h100000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 1, 2, 24'h100000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 2, 0, 24'h080000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 2, 1, 24'hF80000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 2, 2, 24'h200000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 3, 0, 24'hF00000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 3, 1, 24'h180000, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_LOAD, 3, 2, 24'hFC0000, 0, 0, 0, 0, 0, 0, 0);
        // element slot three is ignored by load
        queue_request(CMD_LOAD, 0, 3, 24'h7FFFFF, 15, 15, 15, 3, 65535, 65535, 65535);
        queue_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // no forced element, then a forced element with picks out of order
        queue_request(CMD_EVOLVE, 0, 0, 0, 1, 2, 3, 3, 0, 65535, 52428);
        queue_request(CMD_EVOLVE, 3, 0, 0, 2, 0, 1, 0, 65535, 65535, 65535);
        // repeated pick, and a pick equal to the target
        queue_request(CMD_EVOLVE, 0, 0, 0, 1, 1, 2, 0, 0, 0, 0);
        queue_request(CMD_EVOLVE, 0, 0, 0, 0, 1, 2, 1, 0, 0, 0);
        // a second evolve of the same target before commit
        queue_request(CMD_EVOLVE, 0, 0, 0, 3, 2, 1, 2, 0, 0, 0);
        queue_request(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(CMD_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // random phases under several register settings, the last back at the reset defaults
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(REG_F_SCALE, 24'd65535);
                    write_reg(REG_CROSS_THR, 24'd65536);
                    write_reg(REG_LOW_BOUND, 24'h800000);
                    write_reg(REG_HIGH_BOUND, 24'h7FFFFF);
                end
                2:
                begin
                    write_reg(REG_F_SCALE, 24'd0);
                    write_reg(REG_CROSS_THR, 24'd0);
                    write_reg(REG_LOW_BOUND, 24'hF00000);
                    write_reg(REG_HIGH_BOUND, 24'h100000);
                end
                3:
                begin
                    // crossed bounds: every trial element ends at the high bound
                    write_reg(REG_F_SCALE, 24'd32768);
                    write_reg(REG_CROSS_THR, 24'd32768);
                    write_reg(REG_LOW_BOUND, 24'h100000);
                    write_reg(REG_HIGH_BOUND, 24'hF00000);
                end
                4:
                begin
                    write_reg(REG_F_SCALE, 24'($urandom_range(0, 65535)));
                    write_reg(REG_CROSS_THR, 24'($urandom_range(0, 65536)));
                    write_reg(REG_LOW_BOUND, 24'hD00000);
                    write_reg(REG_HIGH_BOUND, 24'h300000);
                end
                5:
                begin
                    write_reg(REG_F_SCALE, 24'd64225);
                    write_reg(REG_CROSS_THR, 24'd52429);
                    write_reg(REG_LOW_BOUND, 24'hE00000);
                    write_reg(REG_HIGH_BOUND, 24'h200000);
                end
                default: ;
            endcase
            burst_mode = (phase == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_random_request();
            wait_idle();
        end

        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/des_pkg.sv
src/des_if.sv
src/des_fitness.sv
src/des_datapath.sv
src/des_controller.sv
src/differential_evolution_step_top.sv
src/des_checker.sv
tb/tb.sv
